// File: design/pse_pkg.sv
// Shared types and constants for the postfix stack evaluator.
// No dependencies; imported by every module of the block.
`default_nettype none
package pse_pkg;

  localparam int DATA_W      = 32;
  localparam int OP_W        = 3;
  localparam int NUM_W       = 31;
  localparam int DEPTH_W     = 7;
  localparam int STAT_W      = 2;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 48;

  localparam logic [OP_W-1:0] OP_PUSH = 3'd0;
  localparam logic [OP_W-1:0] OP_ADD  = 3'd1;
  localparam logic [OP_W-1:0] OP_SUB  = 3'd2;
  localparam logic [OP_W-1:0] OP_MUL  = 3'd3;
  localparam logic [OP_W-1:0] OP_DIV  = 3'd4;

  localparam logic [STAT_W-1:0] STS_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STS_UNDER = 2'd1;
  localparam logic [STAT_W-1:0] STS_OVER  = 2'd2;
  localparam logic [STAT_W-1:0] STS_DIVZ  = 2'd3;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DIVIDE,
    S_FINISH
  } pse_state_t;

endpackage
`default_nettype wire

// File: design/pse_stack_mem.sv
// Operand stack storage: one write port, two registered read ports.
// Depends on pse_pkg for the data width.
`default_nettype none
module pse_stack_mem #(
  parameter int DEPTH  = 64,
  parameter int ADDR_W = 6
) (
  input  wire logic                      clk,
  input  wire logic                      wr_en,
  input  wire logic [ADDR_W-1:0]         wr_addr,
  input  wire logic [pse_pkg::DATA_W-1:0] wr_data,
  input  wire logic [ADDR_W-1:0]         rd_addr_a,
  input  wire logic [ADDR_W-1:0]         rd_addr_b,
  output logic      [pse_pkg::DATA_W-1:0] rd_data_a,
  output logic      [pse_pkg::DATA_W-1:0] rd_data_b
);
  import pse_pkg::*;

  logic [DATA_W-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule
`default_nettype wire

// File: design/pse_div.sv
// Iterative signed divider: one quotient bit per cycle, truncating toward zero.
// Depends on pse_pkg for the data width.
`default_nettype none
module pse_div (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [pse_pkg::DATA_W-1:0] dividend,
  input  wire logic [pse_pkg::DATA_W-1:0] divisor,
  output logic                            done,
  output logic      [pse_pkg::DATA_W-1:0] quotient
);
  import pse_pkg::*;

  localparam int CNT_W = $clog2(DATA_W);

  logic              busy_r;
  logic              fix_r;
  logic              done_r;
  logic              neg_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [DATA_W-1:0] rem_r;
  logic [DATA_W-1:0] quo_r;
  logic [DATA_W-1:0] mag_b_r;
  logic [DATA_W-1:0] q_r;

  logic [DATA_W-1:0] mag_a;
  logic [DATA_W-1:0] mag_b;
  logic [DATA_W:0]   rem_shift;
  logic [DATA_W:0]   diff;
  logic [DATA_W-1:0] rem_nxt;
  logic [DATA_W-1:0] quo_nxt;

  always_comb begin
    mag_a     = dividend[DATA_W-1] ? (DATA_W'(0) - dividend) : dividend;
    mag_b     = divisor[DATA_W-1]  ? (DATA_W'(0) - divisor)  : divisor;
    rem_shift = {rem_r, quo_r[DATA_W-1]};
    diff      = rem_shift - {1'b0, mag_b_r};
    if (!diff[DATA_W]) begin
      rem_nxt = diff[DATA_W-1:0];
      quo_nxt = {quo_r[DATA_W-2:0], 1'b1};
    end else begin
      rem_nxt = rem_shift[DATA_W-1:0];
      quo_nxt = {quo_r[DATA_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fix_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        fix_r  <= 1'b0;
      end else if (busy_r) begin
        if (cnt_r == CNT_W'(DATA_W - 1)) begin
          busy_r <= 1'b0;
          fix_r  <= 1'b1;
        end
      end else if (fix_r) begin
        fix_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt_r   <= '0;
      rem_r   <= '0;
      quo_r   <= mag_a;
      mag_b_r <= mag_b;
      neg_r   <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
    end else if (busy_r) begin
      cnt_r <= cnt_r + CNT_W'(1);
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
    if (fix_r) begin
      q_r <= neg_r ? (DATA_W'(0) - quo_r) : quo_r;
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule
`default_nettype wire

// File: design/postfix_stack_evaluator.sv
// Postfix (RPN) expression evaluator: top level with control sequencer.
// Depends on pse_pkg, pse_stack_mem and pse_div.
//
// Usage: each request on the in_ channel is one decoded token (push number,
// add, subtract, multiply, divide) with in_tlast on the final token. Every
// token returns exactly one result on the out_ channel: top of stack, depth
// and status, with out_tlast set on the final result, after which the stack
// is empty. The stack lives in a synchronous memory read at two addresses.
// An accepted token goes through the evaluate and finish states to the output
// register for push, add, subtract, multiply and error cases; a divide also
// waits in the divide state while the 32-step radix-2 divider runs, plus its
// start, sign fix and result hand-off.
// A new token is taken once the previous result is in the output register,
// so the next token may be accepted while that result still waits.
// When the receiver stalls, the finished token holds until the output
// register frees up, and no further token is accepted meanwhile.
// Reset (synchronous, active low) empties the stack and drops any pending
// result; the memory contents are not cleared.
`default_nettype none
module postfix_stack_evaluator #(
  parameter int STACK_DEPTH = 64
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  // op [2:0], number [33:3], zero [39:34]
  input  wire logic [pse_pkg::IN_TDATA_W-1:0] in_tdata,
  input  wire logic                           in_tlast,
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  // top_value [31:0], depth [38:32], status [40:39], zero [47:41]
  output logic [pse_pkg::OUT_TDATA_W-1:0]     out_tdata,
  output logic                                out_tlast
);
  import pse_pkg::*;

  localparam int ADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int PTR_W  = $clog2(STACK_DEPTH + 1);

  pse_state_t state_r, state_nxt;

  logic [PTR_W-1:0]  sp_r;
  logic [OP_W-1:0]   op_r;
  logic [NUM_W-1:0]  num_r;
  logic              last_r;

  logic [DATA_W-1:0] res_r,     res_nxt;
  logic [STAT_W-1:0] status_r,  status_nxt;
  logic              wr_en_r,   wr_en_nxt;
  logic [ADDR_W-1:0] wr_addr_r, wr_addr_nxt;
  logic [PTR_W-1:0]  sp_new_r,  sp_new_nxt;

  logic                   out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;
  logic                   out_last_r;

  logic              in_go;
  logic              fin_go;
  logic              out_free;
  logic              div_start;
  logic              div_done;
  logic [DATA_W-1:0] div_q;
  logic [ADDR_W-1:0] rd_addr_a;
  logic [ADDR_W-1:0] rd_addr_b;
  logic [DATA_W-1:0] rd_a;
  logic [DATA_W-1:0] rd_b;
  logic              has_two;
  logic              is_full;
  logic [DATA_W-1:0] top_old;
  logic [PTR_W-1:0]  sp_fin;

  pse_stack_mem #(
    .DEPTH  (STACK_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk       (clk),
    .wr_en     (fin_go & wr_en_r),
    .wr_addr   (wr_addr_r),
    .wr_data   (res_r),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (rd_a),
    .rd_data_b (rd_b)
  );

  pse_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (rd_b),
    .divisor  (rd_a),
    .done     (div_done),
    .quotient (div_q)
  );

  assign has_two  = (sp_r >= PTR_W'(2));
  assign is_full  = (sp_r >= PTR_W'(STACK_DEPTH));
  assign top_old  = (sp_r != '0) ? rd_a : '0;
  assign out_free = !out_valid_r || out_tready;
  assign sp_fin   = last_r ? '0 : sp_new_r;

  // Outputs of the sequencer.
  always_comb begin
    in_tready = (state_r == S_IDLE);
    in_go     = in_tvalid && in_tready;
    fin_go    = (state_r == S_FINISH) && out_free;
    rd_addr_a = ADDR_W'(sp_r - PTR_W'(1));
    rd_addr_b = ADDR_W'(sp_r - PTR_W'(2));
    div_start = (state_r == S_EXEC) && (op_r == OP_DIV) && has_two && (rd_a != '0);
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_go) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        state_nxt = div_start ? S_DIVIDE : S_FINISH;
      end
      S_DIVIDE: begin
        if (div_done) state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Token evaluation.
  always_comb begin
    res_nxt     = res_r;
    status_nxt  = status_r;
    wr_en_nxt   = wr_en_r;
    wr_addr_nxt = wr_addr_r;
    sp_new_nxt  = sp_new_r;
    if (state_r == S_EXEC) begin
      res_nxt     = top_old;
      status_nxt  = STS_OK;
      wr_en_nxt   = 1'b0;
      wr_addr_nxt = rd_addr_b;
      sp_new_nxt  = sp_r;
      case (op_r)
        OP_PUSH: begin
          if (is_full) begin
            status_nxt = STS_OVER;
          end else begin
            res_nxt     = {1'b0, num_r};
            wr_en_nxt   = 1'b1;
            wr_addr_nxt = ADDR_W'(sp_r);
            sp_new_nxt  = PTR_W'(sp_r + PTR_W'(1));
          end
        end
        OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
          if (!has_two) begin
            status_nxt = STS_UNDER;
          end else begin
            wr_en_nxt  = 1'b1;
            sp_new_nxt = PTR_W'(sp_r - PTR_W'(1));
            case (op_r)
              OP_ADD:  res_nxt = rd_b + rd_a;
              OP_SUB:  res_nxt = rd_b - rd_a;
              OP_MUL:  res_nxt = DATA_W'(rd_b * rd_a);
              default: begin
                res_nxt = '0;
                if (rd_a == '0) status_nxt = STS_DIVZ;
              end
            endcase
          end
        end
        default: ;
      endcase
    end else if ((state_r == S_DIVIDE) && div_done) begin
      res_nxt = div_q;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sp_r        <= '0;
      wr_en_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      wr_en_r <= wr_en_nxt;
      if (fin_go) begin
        sp_r        <= sp_fin;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    res_r     <= res_nxt;
    status_r  <= status_nxt;
    wr_addr_r <= wr_addr_nxt;
    sp_new_r  <= sp_new_nxt;
    if (in_go) begin
      op_r   <= in_tdata[OP_W-1:0];
      num_r  <= in_tdata[OP_W +: NUM_W];
      last_r <= in_tlast;
    end
    if (fin_go) begin
      out_data_r <= {(OUT_TDATA_W - DATA_W - DEPTH_W - STAT_W)'(0),
                     status_r, DEPTH_W'(sp_fin), res_r};
      out_last_r <= last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= PTR_W'(STACK_DEPTH))
    else $error("stack pointer beyond stack depth");

  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == S_EXEC))
    else $error("accepted token not evaluated next cycle");

  a_done_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tlast) |-> (out_tdata[DATA_W +: DEPTH_W] == '0))
    else $error("final result with non-empty stack");

  a_divz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tdata[DATA_W + DEPTH_W +: STAT_W] == STS_DIVZ))
      |-> (out_tdata[DATA_W-1:0] == '0))
    else $error("divide by zero result not zero");

  a_div_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIVIDE) |-> !in_tready && !wr_en_nxt == !wr_en_r)
    else $error("token accepted or write state changed during divide");

endmodule
`default_nettype wire

// File: dv/postfix_stack_evaluator_checker.sv
`timescale 1ns / 100ps
// Checker for postfix_stack_evaluator: follows requests on in_, predicts every result
// from its own copy of the operand stack and compares the results seen on out_.
// Depends on pse_pkg.
module postfix_stack_evaluator_checker #(
  parameter int STACK_DEPTH = 64
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  input  wire logic                            in_tready,
  input  wire logic [pse_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  wire logic                            in_tlast,
  input  wire logic                            out_tvalid,
  input  wire logic                            out_tready,
  input  wire logic [pse_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  wire logic                            out_tlast,
  output int                                   fail_count,
  output int                                   pending
);
  import pse_pkg::*;

  typedef struct packed {
    logic [DATA_W-1:0]  top_value;
    logic [DEPTH_W-1:0] depth;
    logic [STAT_W-1:0]  status;
    logic               done;
  } token_result_t;

  token_result_t     expected_results[$];
  logic [DATA_W-1:0] shadow_stack[STACK_DEPTH];
  int unsigned       shadow_count;

  task automatic evaluate_token(input logic [OP_W-1:0] op, input logic [NUM_W-1:0] num,
                                input logic last);
    token_result_t     r;
    logic [DATA_W-1:0] lhs, rhs, lhs_mag, rhs_mag, quo, res;
    r.status = STS_OK;
    if (op == OP_PUSH) begin
      if (shadow_count >= STACK_DEPTH) begin
        r.status = STS_OVER;
      end else begin
        shadow_stack[shadow_count] = {1'b0, num};
        shadow_count++;
      end
    end else if (op <= OP_DIV) begin
      if (shadow_count < 2) begin
        r.status = STS_UNDER;
      end else begin
        rhs = shadow_stack[shadow_count - 1];
        lhs = shadow_stack[shadow_count - 2];
        case (op)
          OP_ADD: res = lhs + rhs;
          OP_SUB: res = lhs - rhs;
          OP_MUL: res = lhs * rhs;
          default: begin
            if (rhs == '0) begin
              res = '0;
              r.status = STS_DIVZ;
            end else begin
              lhs_mag = lhs[DATA_W-1] ? (32'd0 - lhs) : lhs;
              rhs_mag = rhs[DATA_W-1] ? (32'd0 - rhs) : rhs;
              quo = lhs_mag / rhs_mag;
              res = (lhs[DATA_W-1] ^ rhs[DATA_W-1]) ? (32'd0 - quo) : quo;
            end
          end
        endcase
        shadow_count--;
        shadow_stack[shadow_count - 1] = res;
      end
    end
    r.top_value = (shadow_count > 0) ? shadow_stack[shadow_count - 1] : '0;
    if (last) shadow_count = 0;
    r.depth = shadow_count[DEPTH_W-1:0];
    r.done = last;
    expected_results.push_back(r);
  endtask

  task automatic check_field(input string field, input logic [DATA_W-1:0] want,
                             input logic [DATA_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    token_result_t want;
    if (!rst_n) begin
      shadow_count = 0;
      expected_results.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %0h last %0b",
                   $time, out_tdata, out_tlast);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("top_value", want.top_value, out_tdata[DATA_W-1:0]);
          check_field("depth", 32'(want.depth), 32'(out_tdata[DATA_W +: DEPTH_W]));
          check_field("status", 32'(want.status),
                      32'(out_tdata[DATA_W + DEPTH_W +: STAT_W]));
          check_field("done", 32'(want.done), 32'(out_tlast));
        end
      end
      if (in_tvalid && in_tready)
        evaluate_token(in_tdata[OP_W-1:0], in_tdata[OP_W +: NUM_W], in_tlast);
    end
    pending <= expected_results.size();
  end

endmodule

// File: dv/postfix_stack_evaluator_test.sv
`timescale 1ns / 100ps
// Top of the postfix_stack_evaluator testbench: clock, reset, token stimulus and verdict.
// Depends on pse_pkg, postfix_stack_evaluator and postfix_stack_evaluator_checker.
module postfix_stack_evaluator_test;
  import pse_pkg::*;

  localparam int WATCHDOG_LIMIT   = 5000;
  localparam int DRAIN_CYCLES     = 60;
  localparam int TOKENS_PER_PHASE = 310;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   in_tlast   = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;

  int fail_count;
  int pending;
  int idle_pct     = 0;
  int stall_pct    = 0;
  int tokens_sent  = 0;
  int quiet_cycles = 0;

  postfix_stack_evaluator #(.STACK_DEPTH(64)) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  postfix_stack_evaluator_checker #(.STACK_DEPTH(64)) i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [NUM_W-1:0] pick_number();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2, 3:    return NUM_W'($urandom_range(0, 20));
      4:       return NUM_W'($urandom_range(0, 16'hFFFF));
      default: return NUM_W'($urandom);
    endcase
  endfunction

  task automatic send_token(input logic [OP_W-1:0] op, input logic [NUM_W-1:0] num,
                            input logic last);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_TDATA_W - NUM_W - OP_W){1'b0}}, num, op};
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    tokens_sent++;
    @(negedge clk);
  endtask

  // Mostly well-formed expressions; now and then a deep one that may fill the stack,
  // a stray token, or a missing end that lets the stack carry over.
  task automatic send_expression();
    int              pushes_left;
    int              live;
    bit              deep;
    logic [OP_W-1:0] op;
    logic            last;
    deep = ($urandom_range(0, 39) == 0);
    pushes_left = deep ? $urandom_range(60, 70) : $urandom_range(1, 8);
    live = 0;
    while (pushes_left > 0 || live > 1) begin
      if ($urandom_range(0, 11) == 0) begin
        send_token(OP_W'($urandom_range(0, 7)), pick_number(), $urandom_range(0, 7) == 0);
      end else begin
        if (pushes_left > 0 && (live < 2 || deep || $urandom_range(0, 2) == 0)) begin
          op = OP_PUSH;
          pushes_left--;
          live++;
        end else begin
          op = OP_W'(OP_ADD + $urandom_range(0, 3));
          live--;
        end
        last = (pushes_left == 0 && live <= 1) && ($urandom_range(0, 19) != 0);
        send_token(op, pick_number(), last);
      end
    end
  endtask

  initial begin
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    send_token(OP_ADD,  '0,           1'b1);
    send_token(OP_PUSH, '1,           1'b0);
    send_token(OP_PUSH, 31'd1,        1'b0);
    send_token(OP_ADD,  '0,           1'b0);
    send_token(OP_PUSH, '0,           1'b0);
    send_token(OP_PUSH, 31'd1,        1'b0);
    send_token(OP_SUB,  '1,           1'b0);
    send_token(OP_DIV,  '0,           1'b0);
    send_token(OP_PUSH, 31'd5,        1'b0);
    send_token(OP_PUSH, '0,           1'b0);
    send_token(OP_DIV,  '0,           1'b0);
    send_token(3'd5,    '1,           1'b0);
    send_token(3'd6,    '0,           1'b0);
    send_token(3'd7,    '1,           1'b0);
    send_token(OP_MUL,  '0,           1'b0);
    send_token(OP_SUB,  '0,           1'b0);
    send_token(OP_PUSH, 31'd7,        1'b0);
    send_token(OP_PUSH, 31'd2,        1'b0);
    send_token(OP_DIV,  '0,           1'b0);
    send_token(OP_PUSH, '1,           1'b0);
    send_token(OP_MUL,  '0,           1'b1);
    send_token(OP_PUSH, 31'h2AAAAAAA, 1'b1);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 79; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 79; end
        default: begin idle_pct = 33; stall_pct = 33; end
      endcase
      tokens_sent = 0;
      while (tokens_sent < TOKENS_PER_PHASE) send_expression();
    end

    in_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: files.f
design/pse_pkg.sv
design/pse_stack_mem.sv
design/pse_div.sv
design/postfix_stack_evaluator.sv
dv/postfix_stack_evaluator_checker.sv
dv/postfix_stack_evaluator_test.sv
